>>> design/ibp_pkg.sv
// ibp_pkg: shared types and constants of the image border padder
// no dependencies; used by ibp_map and image_border_padder
`default_nettype none

package ibp_pkg;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int PIXEL_WIDTH     = 8;
   localparam int BORDER_WIDTH    = 3;
   localparam int SIZE_REG_WIDTH  = 8;

   typedef enum logic [1:0] {
      PAD_ZERO      = 2'd0,
      PAD_REPLICATE = 2'd1,
      PAD_REFLECT   = 2'd2,
      PAD_WRAP      = 2'd3
   } pad_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PAD_MODE     = 2'd0,
      CSR_BORDER       = 2'd1,
      CSR_FRAME_WIDTH  = 2'd2,
      CSR_FRAME_HEIGHT = 2'd3
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_EMIT = 1'b1
   } kind_type;

endpackage

`default_nettype wire

>>> design/ibp_ram.sv
// ibp_ram: generic synchronous ram, one write port and one registered read port
// no dependencies
`default_nettype none

module ibp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> design/ibp_map.sv
// ibp_map: maps one padded coordinate to a source index for the selected border mode
// depends on ibp_pkg
`default_nettype none

module ibp_map #(
   parameter int PW = 8,
   parameter int NW = 8,
   parameter int IW = 7
) (
   input  wire [PW-1:0]                        pos,
   input  wire [ibp_pkg::BORDER_WIDTH-1:0]     bord,
   input  wire [NW-1:0]                        size,
   input  ibp_pkg::pad_mode_type               mode,
   output logic [IW-1:0]                       idx,
   output logic                                in_frame
);

   localparam int XW = ((PW > NW) ? PW : NW) + 3;

   logic signed [XW-1:0] c_raw;
   logic signed [XW-1:0] n_s;
   logic signed [XW-1:0] c_map;
   logic signed [XW-1:0] c_clamp;
   logic                 below;
   logic                 above;

   always_comb begin
      c_raw    = signed'(XW'(pos)) - signed'(XW'(bord));
      n_s      = signed'(XW'(size));
      below    = c_raw < 0;
      above    = c_raw >= n_s;
      in_frame = 1'b1;
      c_map    = c_raw;
      if (below || above) begin
         case (mode)
            ibp_pkg::PAD_ZERO: begin
               in_frame = 1'b0;
               c_map    = '0;
            end
            ibp_pkg::PAD_REPLICATE: begin
               c_map = c_raw;
            end
            ibp_pkg::PAD_REFLECT: begin
               c_map = below ? (-c_raw - 1) : ((n_s <<< 1) - c_raw - 1);
            end
            ibp_pkg::PAD_WRAP: begin
               c_map = below ? (c_raw + n_s) : (c_raw - n_s);
            end
            default: begin
               c_map = c_raw;
            end
         endcase
      end
      if (c_map < 0) begin
         c_clamp = '0;
      end else if (c_map >= n_s) begin
         c_clamp = n_s - 1;
      end else begin
         c_clamp = c_map;
      end
      idx = c_clamp[IW-1:0];
   end

endmodule

`default_nettype wire

>>> design/image_border_padder.sv
// image_border_padder: loads a frame into a frame store and emits it with a padded border
// depends on ibp_pkg, ibp_ram, ibp_map
// load: busy stays low; emit: the result strobe follows the transfer after the steps
// map, address multiply and ram read; the next emit is taken in the result cycle
// a not-ready emit gives its result in the cycle after the transfer
// reset sets state, counters, config to defaults; frame store, result registers not cleared
// results cannot be stalled: rsp_valid is high for exactly one cycle per result
`default_nettype none

module image_border_padder #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_BORDER = 7
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   start,
   output logic                                  busy,
   input  wire                                   req_kind,
   input  wire [ibp_pkg::PIXEL_WIDTH-1:0]        req_pixel_in,
   output logic                                  rsp_valid,
   output logic [ibp_pkg::PIXEL_WIDTH-1:0]       rsp_pixel_out,
   output logic                                  rsp_row_last,
   output logic                                  rsp_frame_last,
   output logic                                  rsp_not_ready,
   input  wire                                   csr_write_enable,
   input  wire [ibp_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire [ibp_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(DEPTH);
   localparam int LW      = $clog2(DEPTH + 1);
   localparam int SWW     = $clog2(MAX_WIDTH + 1);
   localparam int SWH     = $clog2(MAX_HEIGHT + 1);
   localparam int IWW     = $clog2(MAX_WIDTH);
   localparam int IWH     = $clog2(MAX_HEIGHT);
   localparam int MAXDIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int CW      = $clog2(MAXDIM + 2 * MAX_BORDER + 1);
   localparam int SZW     = ((SWW > SWH) ? SWW : SWH) > ibp_pkg::SIZE_REG_WIDTH ?
                            ((SWW > SWH) ? SWW : SWH) : ibp_pkg::SIZE_REG_WIDTH;
   localparam int PRW     = IWH + SWW;
   localparam int BW      = ibp_pkg::BORDER_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADDR,
      ST_READ,
      ST_OUT
   } state_type;

   // configuration registers
   ibp_pkg::pad_mode_type                   pad_mode_ff;
   logic [BW-1:0]                           border_ff;
   logic [ibp_pkg::SIZE_REG_WIDTH-1:0]      frame_width_ff;
   logic [ibp_pkg::SIZE_REG_WIDTH-1:0]      frame_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_mode_ff     <= ibp_pkg::PAD_ZERO;
         border_ff       <= BW'(1);
         frame_width_ff  <= 8'd128;
         frame_height_ff <= 8'd128;
      end else if (csr_write_enable) begin
         case (ibp_pkg::csr_index_type'(csr_index))
            ibp_pkg::CSR_PAD_MODE:     pad_mode_ff <= ibp_pkg::pad_mode_type'(csr_write_data[1:0]);
            ibp_pkg::CSR_BORDER:       border_ff <= csr_write_data[BW-1:0];
            ibp_pkg::CSR_FRAME_WIDTH:  frame_width_ff <= csr_write_data;
            ibp_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // effective sizes
   logic [SZW-1:0] fw_ext;
   logic [SZW-1:0] fh_ext;
   logic [SWW-1:0] size_w;
   logic [SWH-1:0] size_h;
   logic [BW-1:0]  bord;
   logic [BW-1:0]  bord_w;
   logic [BW-1:0]  bord_h;
   logic [CW:0]    pad_w;
   logic [CW:0]    pad_h;
   logic [LW-1:0]  total;

   always_comb begin
      fw_ext = SZW'(frame_width_ff);
      fh_ext = SZW'(frame_height_ff);
      if (fw_ext == '0) begin
         size_w = SWW'(1);
      end else if (fw_ext > SZW'(MAX_WIDTH)) begin
         size_w = SWW'(MAX_WIDTH);
      end else begin
         size_w = fw_ext[SWW-1:0];
      end
      if (fh_ext == '0) begin
         size_h = SWH'(1);
      end else if (fh_ext > SZW'(MAX_HEIGHT)) begin
         size_h = SWH'(MAX_HEIGHT);
      end else begin
         size_h = fh_ext[SWH-1:0];
      end
      bord   = (int'(border_ff) > MAX_BORDER) ? BW'(MAX_BORDER) : border_ff;
      bord_w = (SWW'(bord) > size_w) ? BW'(size_w) : bord;
      bord_h = (SWH'(bord) > size_h) ? BW'(size_h) : bord;
      pad_w  = (CW + 1)'(size_w) + ((CW + 1)'(bord_w) << 1);
      pad_h  = (CW + 1)'(size_h) + ((CW + 1)'(bord_h) << 1);
      total  = LW'(LW'(size_w) * LW'(size_h));
   end

   // coordinate mapping
   logic [CW-1:0]  out_row_ff;
   logic [CW-1:0]  out_col_ff;
   logic [IWH-1:0] map_row;
   logic [IWW-1:0] map_col;
   logic           in_row;
   logic           in_col;

   ibp_map #(.PW(CW), .NW(SWH), .IW(IWH)) u_map_row (
      .pos      (out_row_ff),
      .bord     (bord_h),
      .size     (size_h),
      .mode     (pad_mode_ff),
      .idx      (map_row),
      .in_frame (in_row)
   );

   ibp_map #(.PW(CW), .NW(SWW), .IW(IWW)) u_map_col (
      .pos      (out_col_ff),
      .bord     (bord_w),
      .size     (size_w),
      .mode     (pad_mode_ff),
      .idx      (map_col),
      .in_frame (in_col)
   );

   // sequencer
   state_type      state_ff, state_in;
   logic [LW-1:0]  load_count_ff, load_count_in;
   logic [CW-1:0]  out_row_in, out_col_in;
   logic [IWH-1:0] src_row_ff, src_row_in;
   logic [IWW-1:0] src_col_ff, src_col_in;
   logic           inside_ff, inside_in;
   logic           row_last_ff, row_last_in;
   logic           frame_last_ff, frame_last_in;
   logic           not_ready_ff, not_ready_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic           accept;
   logic           frame_ready;
   logic           rl;
   logic           fl;
   logic           wr_en;
   logic           rd_en;
   logic [ibp_pkg::PIXEL_WIDTH-1:0] rd_data;

   assign busy        = (state_ff != ST_IDLE) && (state_ff != ST_OUT);
   assign accept      = start && !busy;
   assign frame_ready = load_count_ff >= total;
   assign rl          = ((CW + 1)'(out_col_ff) + (CW + 1)'(1)) >= pad_w;
   assign fl          = rl && (((CW + 1)'(out_row_ff) + (CW + 1)'(1)) >= pad_h);
   assign wr_en       = accept && (req_kind == ibp_pkg::KIND_LOAD) && (load_count_ff < total);
   assign rd_en       = state_ff == ST_READ;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      out_row_in    = out_row_ff;
      out_col_in    = out_col_ff;
      src_row_in    = src_row_ff;
      src_col_in    = src_col_ff;
      inside_in     = inside_ff;
      row_last_in   = row_last_ff;
      frame_last_in = frame_last_ff;
      not_ready_in  = not_ready_ff;
      addr_in       = addr_ff;
      case (state_ff)
         ST_ADDR: begin
            addr_in  = AW'(PRW'(src_row_ff) * PRW'(size_w) + PRW'(src_col_ff));
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: begin
         end
      endcase
      if (accept) begin
         if (req_kind == ibp_pkg::KIND_LOAD) begin
            if (wr_en) begin
               load_count_in = load_count_ff + LW'(1);
            end
            state_in = ST_IDLE;
         end else if (!frame_ready) begin
            not_ready_in  = 1'b1;
            inside_in     = 1'b0;
            row_last_in   = 1'b0;
            frame_last_in = 1'b0;
            state_in      = ST_OUT;
         end else begin
            not_ready_in  = 1'b0;
            inside_in     = in_row && in_col;
            src_row_in    = map_row;
            src_col_in    = map_col;
            row_last_in   = rl;
            frame_last_in = fl;
            state_in      = ST_ADDR;
            if (fl) begin
               out_row_in    = '0;
               out_col_in    = '0;
               load_count_in = '0;
            end else if (rl) begin
               out_col_in = '0;
               out_row_in = out_row_ff + CW'(1);
            end else begin
               out_col_in = out_col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         out_row_ff    <= '0;
         out_col_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         out_row_ff    <= out_row_in;
         out_col_ff    <= out_col_in;
      end
      src_row_ff    <= src_row_in;
      src_col_ff    <= src_col_in;
      inside_ff     <= inside_in;
      row_last_ff   <= row_last_in;
      frame_last_ff <= frame_last_in;
      not_ready_ff  <= not_ready_in;
      addr_ff       <= addr_in;
   end

   ibp_ram #(.WIDTH(ibp_pkg::PIXEL_WIDTH), .DEPTH(DEPTH)) u_frame_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (load_count_ff[AW-1:0]),
      .wr_data (req_pixel_in),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // result transfer
   assign rsp_valid      = state_ff == ST_OUT;
   assign rsp_pixel_out  = inside_ff ? rd_data : '0;
   assign rsp_row_last   = row_last_ff;
   assign rsp_frame_last = frame_last_ff;
   assign rsp_not_ready  = not_ready_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_not_ready |-> !rsp_row_last && !rsp_frame_last && rsp_pixel_out == '0)
      else $error("not-ready result carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> rsp_row_last)
      else $error("frame end without row end");

   assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == ibp_pkg::KIND_EMIT |=> state_ff != ST_IDLE)
      else $error("emit transfer did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_last |-> load_count_ff == '0)
      else $error("load count not cleared at frame end");
`endif

endmodule

`default_nettype wire
